// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent on the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("next");
// Check that a condition always holds.
`define ASSERT_ALWAYS(label, clk, rst_n, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (c)) else $error("always");
`endif

// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: constants and beat types.
package rau_pkg;
    localparam int OperandWidthDefault = 16;
    localparam int NumW = 33;
    localparam int DenW = 32;
    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_SUB  = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_DIV  = 3'd3;
    localparam logic [2:0] KIND_LT   = 3'd4;
    localparam logic [2:0] KIND_EQ   = 3'd5;
    localparam logic [2:0] KIND_NEG  = 3'd6;
    localparam logic [2:0] KIND_NONE = 3'd7;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] a_num;
        logic signed [15:0] a_den;
        logic signed [15:0] b_num;
        logic signed [15:0] b_den;
    } in_beat_t;

    typedef struct packed {
        logic signed [32:0] res_num;
        logic signed [31:0] res_den;
        logic               cmp_flag;
        logic               status;
    } out_beat_t;

    // Divider command and reply between sequencer and divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic done;
    } div_sts_t;
endpackage

// ===== rtl/rau_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module rau_divider
    import rau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [NumW-1:0]  dividend,
    input  logic [NumW-1:0]  divisor,
    output div_sts_t         sts,
    output logic [NumW-1:0]  quotient,
    output logic [NumW-1:0]  remainder
);
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] quo_reg, quo_next;
    logic [NumW-1:0] rem_reg, rem_next;
    logic [NumW-1:0] dvs_reg, dvs_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [NumW:0]   trial;
    logic [NumW:0]   diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NumW-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (ctl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CntW'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract if it fits
            if (!diff[NumW])
            begin
                rem_next = diff[NumW-1:0];
                quo_next = {quo_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[NumW-1:0];
                quo_next = {quo_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ===== rtl/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: sequencer around a shared divider.
// Compare, negate, unused kind and error beats skip the divider and go from forming
// the result straight to output.
// Otherwise Euclid runs its remainders through the 33-bit restoring divider,
// then it divides numerator and denominator by the gcd.
// One beat at a time, next one taken the cycle after the result is loaded; rst_n clears state.
`include "assert_macros.svh"
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OperandWidthDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FORM = 3'd2;
    localparam logic [2:0] ST_GCD  = 3'd3;
    localparam logic [2:0] ST_DNUM = 3'd4;
    localparam logic [2:0] ST_DDEN = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam int PW = 2 * OPERAND_WIDTH;

    logic [2:0] st_reg, st_next;
    logic [2:0] kind_reg;
    logic signed [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [NumW-1:0] rn_reg;
    logic signed [DenW-1:0] rd_reg;
    logic [NumW-1:0] gx_reg, gy_reg;
    logic            wait_reg;
    out_beat_t       out_reg;
    logic            ov_reg;

    div_ctl_t        dctl;
    div_sts_t        dsts;
    logic [NumW-1:0] dvd, dvs, quo, rem;

    logic signed [NumW-1:0] sum;
    logic [NumW-1:0] abs_rn, abs_rd;
    logic bad;

    rau_divider u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
        .sts(dsts), .quotient(quo), .remainder(rem)
    );

    assign in_stall  = (st_reg != ST_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign abs_rn = rn_reg[NumW-1] ? NumW'(-rn_reg) : NumW'(rn_reg);
    assign abs_rd = rd_reg[DenW-1] ? NumW'(-{rd_reg[DenW-1], rd_reg})
                                   : NumW'({1'b0, rd_reg});
    assign bad = (ad_reg == '0) || (kind_reg != KIND_NEG && bd_reg == '0)
              || (kind_reg == KIND_DIV && bn_reg == '0);

    always_comb
    begin
        case (kind_reg)
            KIND_ADD: sum = NumW'(p1_reg) + NumW'(p2_reg);
            KIND_SUB: sum = NumW'(p1_reg) - NumW'(p2_reg);
            default:  sum = NumW'(p1_reg);
        endcase
    end

    // Divider operands per sequencer phase.
    always_comb
    begin
        dctl.start = 1'b0;
        dvd = gx_reg;
        dvs = gy_reg;
        case (st_reg)
            ST_GCD:  dctl.start = !wait_reg && (gy_reg != '0);
            ST_DNUM:
            begin
                dvd = abs_rn;
                dctl.start = !wait_reg;
            end
            ST_DDEN:
            begin
                dvd = abs_rd;
                dctl.start = !wait_reg;
            end
            default: dctl.start = 1'b0;
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (in_valid) st_next = ST_MUL;
            ST_MUL:  st_next = ST_FORM;
            ST_FORM:
                if (bad || kind_reg > KIND_DIV) st_next = ST_OUT;
                else st_next = ST_GCD;
            ST_GCD:  if (!wait_reg && gy_reg == '0) st_next = ST_DNUM;
            ST_DNUM: if (dsts.done) st_next = ST_DDEN;
            ST_DDEN: if (dsts.done) st_next = ST_OUT;
            ST_OUT:  if (!ov_reg || !out_stall) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ov_reg   <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (dctl.start) wait_reg <= 1'b1;
            else if (dsts.done) wait_reg <= 1'b0;
            if (st_reg == ST_OUT && st_next == ST_IDLE) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                // latch the operands, keeping the low OPERAND_WIDTH bits
                kind_reg <= in_data.kind;
                an_reg <= in_data.a_num[OPERAND_WIDTH-1:0];
                ad_reg <= in_data.a_den[OPERAND_WIDTH-1:0];
                bn_reg <= in_data.b_num[OPERAND_WIDTH-1:0];
                bd_reg <= in_data.b_den[OPERAND_WIDTH-1:0];
            end
            ST_MUL:
            begin
                p1_reg <= PW'(an_reg * bd_reg);
                p2_reg <= (kind_reg == KIND_MUL) ? PW'(an_reg * bn_reg)
                                                 : PW'(ad_reg * bn_reg);
                p3_reg <= (kind_reg == KIND_DIV) ? PW'(ad_reg * bn_reg)
                                                 : PW'(ad_reg * bd_reg);
            end
            ST_FORM:
            begin
                rn_reg <= (kind_reg == KIND_MUL) ? NumW'(p2_reg)
                        : (kind_reg == KIND_DIV) ? NumW'(p1_reg) : sum;
                rd_reg <= DenW'(p3_reg);
            end
            default: ;
        endcase
        if (st_reg == ST_FORM)
        begin
            gx_reg <= (kind_reg == KIND_MUL) ? NumW'(p2_reg[PW-1] ? -p2_reg : p2_reg)
                    : (kind_reg == KIND_DIV) ? NumW'(p1_reg[PW-1] ? -p1_reg : p1_reg)
                    : (sum[NumW-1] ? NumW'(-sum) : NumW'(sum));
            gy_reg <= NumW'(p3_reg[PW-1] ? -p3_reg : p3_reg);
        end
        if (st_reg == ST_GCD && dsts.done)
        begin
            gx_reg <= gy_reg;
            gy_reg <= rem;
        end
        if (st_reg == ST_GCD && !wait_reg && gy_reg == '0)
        begin
            // a zero gcd means both parts are zero: divide by one
            if (gx_reg == '0) gy_reg <= NumW'(1);
            else gy_reg <= gx_reg;
        end
        if (st_reg == ST_DNUM && dsts.done)
            rn_reg <= rn_reg[NumW-1] ? NumW'(-quo) : quo;
        if (st_reg == ST_DDEN && dsts.done)
            rd_reg <= rd_reg[DenW-1] ? DenW'(-quo) : DenW'(quo);
        if (st_reg == ST_OUT && st_next == ST_IDLE)
        begin
            if (bad || kind_reg == KIND_NONE)
            begin
                // errors and the unused kind give 0/1
                out_reg.res_num  <= '0;
                out_reg.res_den  <= DenW'(1);
                out_reg.cmp_flag <= 1'b0;
                out_reg.status   <= (kind_reg != KIND_NONE);
            end
            else
            begin
                case (kind_reg)
                    KIND_LT, KIND_EQ:
                    begin
                        out_reg.res_num  <= '0;
                        out_reg.res_den  <= DenW'(1);
                        out_reg.cmp_flag <= (kind_reg == KIND_LT) ? (p1_reg < p2_reg)
                                                                  : (p1_reg == p2_reg);
                        out_reg.status   <= 1'b0;
                    end
                    KIND_NEG:
                    begin
                        out_reg.res_num  <= -NumW'(an_reg);
                        out_reg.res_den  <= DenW'(ad_reg);
                        out_reg.cmp_flag <= 1'b0;
                        out_reg.status   <= 1'b0;
                    end
                    default:
                    begin
                        out_reg.res_num  <= rn_reg;
                        out_reg.res_den  <= rd_reg;
                        out_reg.cmp_flag <= 1'b0;
                        out_reg.status   <= 1'b0;
                    end
                endcase
            end
        end
    end

    `ASSERT_NEXT(a_busy_stall, clk, rst_n, st_reg == ST_MUL, in_stall)
    `ASSERT_ALWAYS(a_wait_div, clk, rst_n, !(dctl.start && wait_reg))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, ov_reg && out_stall, ov_reg)
endmodule

// ===== tb/tb_rational_arith_unit.sv =====
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 1ps

module tb_rational_arith_unit;
    import rau_pkg::*;

    localparam int  MaxCycles  = 12000000;
    localparam int  RandItems  = 1400;
    localparam int  QuietItems = 150;  // last random beats run with no idling
    localparam int  DrainWait  = 60;

    // One directed row: a beat and, where obvious, its typed-in result.
    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t result;
    } vector_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;

    out_beat_t pending_results[$];
    vector_t   vectors[$];
    int        error_count;
    int        cycle_count;
    bit        quiet;
    int        stall_left;
    bit        typed_armed;
    out_beat_t typed_result;

    rational_arith_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Compute the reduced fraction, flag and status for one operand beat.
    function automatic out_beat_t rational_result(in_beat_t b);
        longint          an;
        longint          ad;
        longint          bn;
        longint          bd;
        longint          rn;
        longint          rd;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        bit              flag;
        bit              err;
        bit              reduce;
        out_beat_t       r;
        an = b.a_num;
        ad = b.a_den;
        bn = b.b_num;
        bd = b.b_den;
        rn = 0;
        rd = 1;
        flag = 1'b0;
        err = 1'b0;
        reduce = 1'b0;
        if (b.kind != KIND_NONE && (ad == 0 || (b.kind != KIND_NEG && bd == 0)))
        begin
            err = 1'b1;
        end
        else
        begin
            case (b.kind)
                KIND_ADD:
                begin
                    rn = an * bd + ad * bn;
                    rd = ad * bd;
                    reduce = 1'b1;
                end
                KIND_SUB:
                begin
                    rn = an * bd - ad * bn;
                    rd = ad * bd;
                    reduce = 1'b1;
                end
                KIND_MUL:
                begin
                    rn = an * bn;
                    rd = ad * bd;
                    reduce = 1'b1;
                end
                KIND_DIV:
                begin
                    if (bn == 0)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        rn = an * bd;
                        rd = ad * bn;
                        reduce = 1'b1;
                    end
                end
                KIND_LT: flag = (an * bd < ad * bn);
                KIND_EQ: flag = (an * bd == ad * bn);
                KIND_NEG:
                begin
                    rn = -an;
                    rd = ad;
                end
                default: ;
            endcase
        end
        if (reduce)
        begin
            // Euclid on magnitudes; signs stay as computed
            x = (rn < 0) ? longint'(-rn) : longint'(rn);
            y = (rd < 0) ? longint'(-rd) : longint'(rd);
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            if (x == 0)
            begin
                x = 1;
            end
            rn = rn / longint'(x);
            rd = rd / longint'(x);
        end
        r.res_num  = rn[32:0];
        r.res_den  = rd[31:0];
        r.cmp_flag = flag;
        r.status   = err;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 field, got, want, cycle_count);
        error_count++;
    endtask

    task automatic add_vector(logic [2:0] k, int an, int ad, int bn, int bd,
                              bit typed, longint rn, longint rd, bit flag, bit err);
        vector_t v;
        v.beat = '{kind: k, a_num: an[15:0], a_den: ad[15:0],
                   b_num: bn[15:0], b_den: bd[15:0]};
        v.typed = typed;
        v.result = '{res_num: rn[32:0], res_den: rd[31:0], cmp_flag: flag, status: err};
        vectors = {vectors, v};
    endtask

    // Hold the beat until taken, then maybe drop valid for an idle burst.
    task automatic send_beat(in_beat_t b);
        in_valid <= 1'b1;
        in_data  <= b;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    function automatic in_beat_t random_beat();
        in_beat_t b;
        b.kind = 3'($urandom_range(0, 7));
        b = '{kind: b.kind, a_num: 16'($urandom), a_den: 16'($urandom),
              b_num: 16'($urandom), b_den: 16'($urandom)};
        // mix in small operands so zeros, equal values and big gcds show up
        if ($urandom_range(0, 2) == 0)
        begin
            b.a_num = 16'($signed($urandom_range(0, 12)) - 6);
            b.a_den = 16'($signed($urandom_range(0, 12)) - 6);
            b.b_num = 16'($signed($urandom_range(0, 12)) - 6);
            b.b_den = 16'($signed($urandom_range(0, 12)) - 6);
        end
        return b;
    endfunction

    // Sample at the falling edge: values there hold through the next rising edge.
    always @(negedge clk)
    begin
        out_beat_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            // typed-in rows replace the prediction
            if (typed_armed)
                pending_results = {pending_results, typed_result};
            else
                pending_results = {pending_results, rational_result(in_data)};
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.res_num !== want.res_num)
                    report_mismatch("res_num", longint'(out_data.res_num),
                                    longint'(want.res_num));
                if (out_data.res_den !== want.res_den)
                    report_mismatch("res_den", longint'(out_data.res_den),
                                    longint'(want.res_den));
                if (out_data.cmp_flag !== want.cmp_flag)
                    report_mismatch("cmp_flag", out_data.cmp_flag, want.cmp_flag);
                if (out_data.status !== want.status)
                    report_mismatch("status", out_data.status, want.status);
            end
        end
    end

    // Receiver stall in random bursts; none once the run goes quiet.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 14) - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MaxCycles)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        vector_t v;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        error_count = 0;
        cycle_count = 0;
        quiet = 1'b0;
        stall_left = 0;
        typed_armed = 1'b0;
        typed_result = '0;

        // zero denominators and division by zero give an error status and 0/1
        add_vector(KIND_ADD, 3, 0, 1, 2, 1, 0, 1, 0, 1);
        add_vector(KIND_LT, 1, 2, 1, 0, 1, 0, 1, 0, 1);
        add_vector(KIND_EQ, 5, 5, 0, 0, 1, 0, 1, 0, 1);
        add_vector(KIND_NEG, 7, 0, 1, 1, 1, 0, 1, 0, 1);
        add_vector(KIND_DIV, 1, 2, 0, 3, 1, 0, 1, 0, 1);
        // negate ignores b entirely, even a zero b_den
        add_vector(KIND_NEG, 5, 3, 0, 0, 1, -5, 3, 0, 0);
        add_vector(KIND_NEG, -32768, -32768, 1, 1, 1, 32768, -32768, 0, 0);
        // unused kind: 0/1 with no error
        add_vector(KIND_NONE, 9, 0, 9, 0, 1, 0, 1, 0, 0);
        // compares: numerator 0, denominator 1
        add_vector(KIND_EQ, 1, 2, 2, 4, 1, 0, 1, 1, 0);
        add_vector(KIND_LT, 1, 3, 1, 2, 1, 0, 1, 1, 0);
        add_vector(KIND_LT, 1, 2, 1, 2, 1, 0, 1, 0, 0);
        // zero numerator result reduces to 0/1
        add_vector(KIND_MUL, 0, 3, 1, 2, 1, 0, 1, 0, 0);
        add_vector(KIND_SUB, 1, 2, 2, 4, 0, 0, 0, 0, 0);
        add_vector(KIND_SUB, 1, -2, 1, -2, 0, 0, 0, 0, 0);
        // extremes of the operand range
        add_vector(KIND_ADD, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0);
        add_vector(KIND_ADD, 32767, 1, 32767, 1, 0, 0, 0, 0, 0);
        add_vector(KIND_SUB, -32768, 32767, 32767, -32768, 0, 0, 0, 0, 0);
        add_vector(KIND_MUL, -32768, 32767, -32768, 32767, 0, 0, 0, 0, 0);
        add_vector(KIND_DIV, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 0);
        add_vector(KIND_LT, -32768, 1, 32767, 1, 0, 0, 0, 0, 0);
        add_vector(KIND_EQ, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0);
        // ordinary reductions with negative denominators kept
        add_vector(KIND_ADD, 1, 6, 1, -3, 0, 0, 0, 0, 0);
        add_vector(KIND_DIV, 4, 9, -2, 3, 0, 0, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; the sampler takes the typed result when armed.
        foreach (vectors[i])
        begin
            v = vectors[i];
            typed_armed = v.typed;
            typed_result = v.result;
            send_beat(v.beat);
        end
        typed_armed = 1'b0;

        // Random beats, with one full drain partway through.
        for (int n = 0; n < RandItems; n++)
        begin
            if (n == RandItems / 2)
            begin
                in_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge clk);
            end
            if (n == RandItems - QuietItems)
            begin
                quiet = 1'b1;
            end
            send_beat(random_beat());
        end
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (DrainWait) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
